### hw/rtl/range_add_count_at_most_defines.svh
// Assertion macros shared by the range add and count block.
`ifndef RANGE_ADD_COUNT_AT_MOST_DEFINES_SVH
`define RANGE_ADD_COUNT_AT_MOST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/rac_pkg.sv
// Types, constants and control structs of the range add and count block.
package rac_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int IDX_W       = 13;
   localparam int CNT_W       = 13;
   localparam int OPV_W       = 32;
   localparam int VAL_W       = 64;

   localparam logic [IDX_W-1:0] ELEM_COUNT_RESET = 13'd4096;
   localparam logic [CNT_W-1:0] CNT_MAX          = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_COUNT = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } rac_state_type;

   typedef struct packed {
      logic capture;
      logic load_write;
      logic walk_start;
      logic issue;
      logic result_load;
   } rac_cmd_type;

   typedef struct packed {
      logic         bad;
      req_kind_type kind;
      logic         last;
      logic         out_free;
   } rac_status_type;

endpackage

### hw/rtl/rac_req_if.sv
// Request channel interface: valid/ready handshake with the request payload.
interface rac_req_if import rac_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              req_type;
   logic [IDX_W-1:0]        left_index;
   logic [IDX_W-1:0]        right_index;
   logic signed [OPV_W-1:0] operand_value;

   modport source (output valid, output req_type, output left_index,
                   output right_index, output operand_value, input ready);
   modport sink (input valid, input req_type, input left_index,
                 input right_index, input operand_value, output ready);
endinterface

### hw/rtl/rac_rsp_if.sv
// Response channel interface: valid/ready handshake with the result payload.
interface rac_rsp_if import rac_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] match_count;
   logic             range_error;

   modport source (output valid, output match_count, output range_error, input ready);
   modport sink (input valid, input match_count, input range_error, output ready);
endinterface

### hw/rtl/rac_dp.sv
// Datapath: request registers, entry memory, saturating adder, counter, output register.
module rac_dp import rac_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  rac_cmd_type             cmd,
   output rac_status_type          status,
   input  logic [1:0]              req_type,
   input  logic [IDX_W-1:0]        left_index,
   input  logic [IDX_W-1:0]        right_index,
   input  logic signed [OPV_W-1:0] operand_value,
   input  logic                    csr_wr_en,
   input  logic [IDX_W-1:0]        csr_wr_data,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [CNT_W-1:0]        rsp_match_count,
   output logic                    rsp_range_error
);

   logic [IDX_W-1:0]        elem_count_ff;
   req_kind_type            kind_ff;
   logic [IDX_W-1:0]        lo_ff;
   logic [IDX_W-1:0]        hi_ff;
   logic signed [OPV_W-1:0] opv_ff;
   logic signed [VAL_W-1:0] bound_ff;
   logic [ADDR_W-1:0]       walk_addr_ff;
   logic [ADDR_W-1:0]       proc_addr_ff;
   logic                    proc_valid_ff;
   logic signed [VAL_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]        count_ff;
   logic                    rsp_valid_ff;
   logic [CNT_W-1:0]        rsp_count_ff;
   logic                    rsp_error_ff;

   logic [VAL_W-1:0]        mem [TABLE_DEPTH];

   logic [IDX_W-1:0]        n_limit;
   logic                    bad;
   logic signed [VAL_W-1:0] opv_ext;
   logic signed [VAL_W-1:0] opv_sq;
   logic [VAL_W:0]          sum_wide;
   logic [VAL_W-1:0]        sat_sum;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [VAL_W-1:0]        wr_data;
   logic [ADDR_W-1:0]       last_addr;

   // The count in use is the configured count limited to the table depth.
   always_comb begin
      if (32'(elem_count_ff) > 32'(TABLE_DEPTH)) begin
         n_limit = IDX_W'(TABLE_DEPTH);
      end else begin
         n_limit = elem_count_ff;
      end
   end

   always_comb begin
      case (kind_ff)
         REQ_LOAD:  bad = (lo_ff == '0) || (lo_ff > n_limit);
         REQ_ADD,
         REQ_COUNT: bad = (lo_ff == '0) || (hi_ff == '0) || (lo_ff > hi_ff) ||
                          (hi_ff > n_limit);
         default:   bad = 1'b0;
      endcase
   end

   assign last_addr = ADDR_W'(hi_ff - IDX_W'(1));

   assign status.bad      = bad;
   assign status.kind     = kind_ff;
   assign status.last     = (walk_addr_ff == last_addr);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Saturating add of the sign-extended amount to the entry read last cycle.
   assign opv_ext  = VAL_W'(opv_ff);
   assign sum_wide = {rd_data_ff[VAL_W-1], rd_data_ff} + {opv_ext[VAL_W-1], opv_ext};
   always_comb begin
      if (sum_wide[VAL_W] != sum_wide[VAL_W-1]) begin
         sat_sum = sum_wide[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         sat_sum = sum_wide[VAL_W-1:0];
      end
   end

   // The square of a sign-extended 32-bit root always fits in 63 bits.
   assign opv_sq = opv_ext * opv_ext;

   always_comb begin
      if (cmd.load_write) begin
         wr_en   = 1'b1;
         wr_addr = ADDR_W'(lo_ff - IDX_W'(1));
         wr_data = opv_ext;
      end else begin
         wr_en   = proc_valid_ff && (kind_ff == REQ_ADD);
         wr_addr = proc_addr_ff;
         wr_data = sat_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[walk_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_count_ff <= ELEM_COUNT_RESET;
      end else if (csr_wr_en) begin
         elem_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind_type'(req_type);
         lo_ff   <= left_index;
         hi_ff   <= right_index;
         opv_ff  <= operand_value;
      end
      bound_ff     <= opv_sq;
      proc_addr_ff <= walk_addr_ff;
      if (cmd.walk_start) begin
         walk_addr_ff <= ADDR_W'(lo_ff - IDX_W'(1));
      end else if (cmd.issue) begin
         walk_addr_ff <= walk_addr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_valid_ff <= 1'b0;
      end else begin
         proc_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         count_ff <= '0;
      end else if (proc_valid_ff && (kind_ff == REQ_COUNT) &&
                   (rd_data_ff <= bound_ff) && (count_ff != CNT_MAX)) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_error_ff <= bad;
         rsp_count_ff <= (!bad && (kind_ff == REQ_COUNT)) ? count_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_count = rsp_count_ff;
   assign rsp_range_error = rsp_error_ff;

endmodule

### hw/rtl/rac_ctrl.sv
// Controller: sequences check, table walk (range add and count only) and result hand-off for each transaction.
`include "range_add_count_at_most_defines.svh"

module rac_ctrl import rac_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  rac_status_type status,
   output rac_cmd_type    cmd
);

   rac_state_type state_ff;
   rac_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.bad || (status.kind == REQ_LOAD) || (status.kind == REQ_NONE)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_CHECK: begin
            cmd.load_write = !status.bad && (status.kind == REQ_LOAD);
            cmd.walk_start = !status.bad &&
                             ((status.kind == REQ_ADD) || (status.kind == REQ_COUNT));
         end
         ST_WALK: begin
            cmd.issue = 1'b1;
         end
         ST_DONE: begin
            cmd.result_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `RAC_ASSERT_NEXT(a_bad_skips_walk, (state_ff == ST_CHECK) && status.bad, state_ff == ST_DONE, "bad indices entered the table walk")
   `RAC_ASSERT_NEXT(a_walk_ends, (state_ff == ST_WALK) && status.last, state_ff == ST_DRAIN, "walk did not stop at the last index")
   `RAC_ASSERT_NEXT(a_result_handoff, (state_ff == ST_DONE) && status.out_free, (state_ff == ST_IDLE) && !req_ready == 1'b0, "result hand-off did not return to idle")

endmodule

### hw/rtl/range_add_count_at_most.sv
// Each transaction takes one request and returns exactly one response. A load,
// a request with bad indices, or an unknown request type goes from the check
// straight to the result hand-off; a range add or range count first walks the
// table from left_index to right_index, reading one 64-bit entry per cycle
// from a single-port-read memory of 4096 entries, and a range add writes the
// saturated sum back in the cycle after the read. A finished response waits in
// an output register, so the next request is accepted while it is pending.
// element_count is written through csr_wr_en/csr_wr_data; the user must write
// it only while no transaction is in flight, as the block does not enforce this.
module range_add_count_at_most import rac_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   rac_req_if.sink          req,
   rac_rsp_if.source        rsp,
   input  logic             csr_wr_en,
   input  logic [IDX_W-1:0] csr_wr_data
);

   rac_cmd_type    cmd;
   rac_status_type status;

   rac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rac_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req.req_type),
      .left_index      (req.left_index),
      .right_index     (req.right_index),
      .operand_value   (req.operand_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp.ready),
      .rsp_valid       (rsp.valid),
      .rsp_match_count (rsp.match_count),
      .rsp_range_error (rsp.range_error)
   );

endmodule
